FILE: src/ssd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the stereo SAD disparity block.
package ssd_pkg;

	// Width of the size registers and of all internal row and column values.
	localparam int DIM_W = 8;
	localparam int PIX_W = 8;
	// One column of three absolute differences, and a whole 3x3 window.
	localparam int COLSUM_W = 10;
	localparam int SUM_W = 12;

	localparam logic [DIM_W-1:0] DIM_MIN = 8'd3;
	localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	typedef struct packed {
		logic             opcode;
		logic [6:0]       row;
		logic [6:0]       col;
		logic [PIX_W-1:0] left_pixel;
		logic [PIX_W-1:0] right_pixel;
	} item_t;

	typedef struct packed {
		logic [7:0] disparity;
		logic       out_of_range;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             accept;
		logic             rd_left;
		logic             rd_right;
		logic             emit;
		logic [DIM_W-1:0] cnt;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic special;
		logic last_col;
		logic scan_done;
	} status_t;

	function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

FILE: src/ssd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module ssd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/ssd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences loads and disparity queries.
module ssd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             opcode,
	input  ssd_pkg::status_t status,
	output ssd_pkg::cmd_t    cmd,
	output logic             busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLASS = 3'd1;
	localparam logic [2:0] S_LREAD = 3'd2;
	localparam logic [2:0] S_RREAD = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	localparam logic [ssd_pkg::DIM_W-1:0] LEFT_LAST = 8'd2;

	logic [2:0] state_q, state_d;
	logic [ssd_pkg::DIM_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.cnt = cnt_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = start;
				if (start && opcode == ssd_pkg::OP_QUERY) begin
					state_d = S_CLASS;
				end
			end
			S_CLASS: begin
				cnt_d = '0;
				state_d = status.special ? S_EMIT : S_LREAD;
			end
			S_LREAD: begin
				cmd.rd_left = 1'b1;
				if (cnt_q == LEFT_LAST) begin
					cnt_d = '0;
					state_d = S_RREAD;
				end else begin
					cnt_d = cnt_q + 8'd1;
				end
			end
			S_RREAD: begin
				cmd.rd_right = 1'b1;
				if (status.last_col) begin
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + 8'd1;
				end
			end
			S_DRAIN: begin
				if (status.scan_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: src/ssd_datapath.sv
`timescale 1ns / 1ps
// Datapath: image stores, window registers, SAD pipeline and best-match tracking.
module ssd_datapath #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ssd_pkg::item_t                       item,
	input  logic                                 cfg_we,
	input  logic [ssd_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [ssd_pkg::DIM_W-1:0]            cfg_wdata,
	input  ssd_pkg::cmd_t                        cmd,
	output ssd_pkg::status_t                     status,
	output logic                                 done,
	output ssd_pkg::result_t                     result
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = $clog2(DEPTH);
	localparam int XW = AW + 9;
	localparam int DW = ssd_pkg::DIM_W;
	localparam int PW = ssd_pkg::PIX_W;
	localparam logic [DW-1:0] COLS_CAP = (MAX_COLS > 255) ? 8'd255 : 8'(MAX_COLS);
	localparam logic [DW-1:0] ROWS_CAP = (MAX_ROWS > 255) ? 8'd255 : 8'(MAX_ROWS);

	// Size registers and their clamped values.
	logic [DW-1:0] width_q, height_q;
	logic [DW-1:0] w_eff, h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ssd_pkg::DIM_RESET;
			height_q <= ssd_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				ssd_pkg::CFG_IMAGE_WIDTH:  width_q <= cfg_wdata;
				ssd_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign w_eff = (width_q < ssd_pkg::DIM_MIN) ? ssd_pkg::DIM_MIN :
		((width_q > COLS_CAP) ? COLS_CAP : width_q);
	assign h_eff = (height_q < ssd_pkg::DIM_MIN) ? ssd_pkg::DIM_MIN :
		((height_q > ROWS_CAP) ? ROWS_CAP : height_q);

	// Query registers and row base addresses of the three window rows.
	logic [DW-1:0] row_q, col_q;
	logic [AW-1:0] rowbase_q [3];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			row_q <= {1'b0, item.row};
			col_q <= {1'b0, item.col};
			for (int i = 0; i < 3; i++) begin
				rowbase_q[i] <= AW'((XW'(item.row) + XW'(i) - XW'(1)) * XW'(MAX_COLS));
			end
		end
	end

	logic oor_w, border_w, special_w;
	assign oor_w = (row_q >= h_eff) || (col_q >= w_eff);
	assign border_w = (row_q == '0) || (row_q == h_eff - 8'd1) ||
		(col_q == '0) || (col_q == w_eff - 8'd1);
	assign special_w = oor_w || border_w;

	// Store writes for loads, reads for queries.
	logic [XW-1:0] wr_full;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic [DW-1:0] rd_col;
	logic [AW-1:0] rd_addr [3];
	logic [PW-1:0] l_rd [3];
	logic [PW-1:0] r_rd [3];

	assign wr_full = XW'(item.row) * XW'(MAX_COLS) + XW'(item.col);
	assign wr_addr = wr_full[AW-1:0];
	assign wr_en = cmd.accept && (item.opcode == ssd_pkg::OP_LOAD) &&
		(int'(item.row) < MAX_ROWS) && (int'(item.col) < MAX_COLS);
	assign rd_col = cmd.rd_left ? (col_q - 8'd1 + cmd.cnt) : cmd.cnt;

	for (genvar g = 0; g < 3; g++) begin : g_rows
		assign rd_addr[g] = rowbase_q[g] + AW'(rd_col);

		ssd_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_left (
			.clk  (clk),
			.we   (wr_en),
			.waddr(wr_addr),
			.wdata(item.left_pixel),
			.re   (cmd.rd_left),
			.raddr(rd_addr[g]),
			.rdata(l_rd[g])
		);

		ssd_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_right (
			.clk  (clk),
			.we   (wr_en),
			.waddr(wr_addr),
			.wdata(item.right_pixel),
			.re   (cmd.rd_right),
			.raddr(rd_addr[g]),
			.rdata(r_rd[g])
		);
	end

	// Valid bits of the read and SAD pipeline, and the column of the last right read.
	logic lv_s1, rv_s1, win_v_s2, v_s3, v_s4, done_q;
	logic [DW-1:0] rcol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_s1 <= 1'b0;
			rv_s1 <= 1'b0;
			win_v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			lv_s1 <= cmd.rd_left;
			rv_s1 <= cmd.rd_right;
			win_v_s2 <= rv_s1 && (rcol_s1 >= 8'd2);
			v_s3 <= win_v_s2;
			v_s4 <= v_s3;
			done_q <= cmd.emit;
		end
	end

	// Window registers are indexed [column][row]; column 2 is the newest.
	logic [PW-1:0]                   lwin_q [3][3];
	logic [PW-1:0]                   rwin_q [3][3];
	logic [DW-1:0]                   win_k_s2, k_s3, k_s4;
	logic [ssd_pkg::COLSUM_W-1:0]    colsum_w [3];
	logic [ssd_pkg::COLSUM_W-1:0]    colsum_s3 [3];
	logic [ssd_pkg::SUM_W-1:0]       total_w, total_s4, best_sum_q;
	logic [DW-1:0]                   best_col_q;
	ssd_pkg::result_t                result_q;

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			colsum_w[m] = '0;
			for (int r = 0; r < 3; r++) begin
				colsum_w[m] = colsum_w[m] +
					ssd_pkg::COLSUM_W'(ssd_pkg::abs_diff(lwin_q[m][r], rwin_q[m][r]));
			end
		end
	end

	assign total_w = ssd_pkg::SUM_W'(colsum_s3[0]) + ssd_pkg::SUM_W'(colsum_s3[1]) +
		ssd_pkg::SUM_W'(colsum_s3[2]);

	always_ff @(posedge clk) begin
		if (cmd.rd_right) begin
			rcol_s1 <= cmd.cnt;
		end
		if (lv_s1) begin
			for (int r = 0; r < 3; r++) begin
				lwin_q[0][r] <= lwin_q[1][r];
				lwin_q[1][r] <= lwin_q[2][r];
				lwin_q[2][r] <= l_rd[r];
			end
		end
		if (rv_s1) begin
			for (int r = 0; r < 3; r++) begin
				rwin_q[0][r] <= rwin_q[1][r];
				rwin_q[1][r] <= rwin_q[2][r];
				rwin_q[2][r] <= r_rd[r];
			end
		end
		win_k_s2 <= rcol_s1 - 8'd1;
		colsum_s3 <= colsum_w;
		k_s3 <= win_k_s2;
		total_s4 <= total_w;
		k_s4 <= k_s3;
		if (v_s4 && ((k_s4 == 8'd1) || (total_s4 < best_sum_q))) begin
			best_sum_q <= total_s4;
			best_col_q <= k_s4;
		end
		if (cmd.emit) begin
			result_q.disparity <= special_w ? 8'd0 : ssd_pkg::abs_diff(col_q, best_col_q);
			result_q.out_of_range <= oor_w;
		end
	end

	assign status.special = special_w;
	assign status.last_col = (cmd.cnt == w_eff - 8'd1);
	assign status.scan_done = v_s4 && (k_s4 == w_eff - 8'd2);
	assign done = done_q;
	assign result = result_q;

	// The result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	// An out-of-range result never carries a disparity.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.out_of_range) |-> (result_q.disparity == 8'd0))
		else $error("out-of-range result with nonzero disparity");

	// Every scored candidate is an interior column.
	a_cand_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ((k_s4 >= 8'd1) && (k_s4 <= w_eff - 8'd2)))
		else $error("candidate column outside the interior");

	// The SAD pipeline is empty when a result is formed.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!v_s3 && !v_s4 && !win_v_s2))
		else $error("result formed while candidates are still in flight");

endmodule

FILE: src/stereo_sad_disparity.sv
`timescale 1ns / 1ps
// Top level of the 3x3 SAD stereo block matcher.
//
// A load transfer writes one left/right pixel pair; busy stays low, so
// another transfer may follow at once, and loads beyond the store size are
// dropped. A query transfer raises busy until its result has been formed.
// A query outside the configured image, or on its border, is classified
// and then goes straight to forming the result, with no store reads. An
// interior query is classified, reads the left window, streams the right
// image past the window over every column of the image, drains the SAD
// pipeline, forms the result and raises the result strobe. The right scan
// is paced by the single read port of each store copy, which delivers
// one three-row column per cycle. The result appears on result for exactly
// one cycle, marked by done, and must be captured then: there is no back
// pressure on the result side. Each image is held in three identical store
// copies, one per window row, written together on a load. The size
// registers may be written only while busy is low; values are clamped to the
// range 3 to the store dimension.
module stereo_sad_disparity #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ssd_pkg::item_t                item,
	output logic                          done,
	output ssd_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ssd_pkg::DIM_W-1:0]     cfg_wdata
);

	// Command and status between the sequencer and the datapath.
	ssd_pkg::cmd_t    cmd;
	ssd_pkg::status_t status;

	// The controller owns the handshake: a transfer is accepted while idle.
	ssd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(item.opcode),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	// The datapath holds the stores, the size registers and the SAD pipeline.
	ssd_datapath #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.status   (status),
		.done     (done),
		.result   (result)
	);

endmodule

FILE: sim/stereo_sad_disparity_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the stereo SAD disparity block with directed and random traffic.
module stereo_sad_disparity_tb;

	localparam int CLK_PERIOD = 12;
	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 128;
	// The slowest legal run stays well under this limit.
	localparam int TIMEOUT_CYCLES = 2_000_000;
	localparam int RANDOM_ITEMS = 780;
	// Longer than an interior query on the widest image takes to finish.
	localparam int DRAIN_CYCLES = MAX_COLS + 16;
	// Loads produce no result, so settle pauses this long for a trailing load.
	localparam int LOAD_SETTLE_CYCLES = 4;
	localparam int GAP_PCT = 36;

	// Ways of filling a three-row band of both images.
	typedef enum int {
		FILL_FLAT,
		FILL_SHIFTED,
		FILL_NARROW,
		FILL_EXTREME
	} fill_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	ssd_pkg::item_t                item = '0;
	logic                          done;
	ssd_pkg::result_t              result;
	logic                          cfg_we = 1'b0;
	logic [ssd_pkg::CFG_IDX_W-1:0] cfg_idx = ssd_pkg::CFG_IMAGE_WIDTH;
	logic [ssd_pkg::DIM_W-1:0]     cfg_wdata = '0;

	// Mirror of both images, a mark per pixel that has been loaded, and the raw
	// size registers as last written.
	logic [ssd_pkg::PIX_W-1:0] left_img [MAX_ROWS*MAX_COLS];
	logic [ssd_pkg::PIX_W-1:0] right_img [MAX_ROWS*MAX_COLS];
	bit                        pixel_loaded [MAX_ROWS*MAX_COLS];
	logic [ssd_pkg::DIM_W-1:0] width_reg = ssd_pkg::DIM_RESET;
	logic [ssd_pkg::DIM_W-1:0] height_reg = ssd_pkg::DIM_RESET;

	// Disparity results still owed by the block, oldest first.
	ssd_pkg::result_t pending_results[$];
	int               mismatch_count = 0;
	int               items_sent = 0;
	bit               gaps_on = 1'b1;

	stereo_sad_disparity #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Disparity predictor.
	// ------------------------------------------------------------------

	// Size registers are clamped to 3 .. store dimension when they are used.
	function automatic int clamp_dim(input logic [ssd_pkg::DIM_W-1:0] v, input int limit);
		if (v < ssd_pkg::DIM_MIN)
			return ssd_pkg::DIM_MIN;
		if (v > limit)
			return limit;
		return v;
	endfunction

	function automatic int cur_width();
		return clamp_dim(width_reg, MAX_COLS);
	endfunction

	function automatic int cur_height();
		return clamp_dim(height_reg, MAX_ROWS);
	endfunction

	// Sum of absolute differences between the left window centred on column lc
	// and the right window centred on column rc, both on rows r-1 .. r+1.
	function automatic int window_sad(input int r, input int lc, input int rc);
		int sum;
		int a;
		int b;
		sum = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				a = left_img[(r + dr) * MAX_COLS + lc + dc];
				b = right_img[(r + dr) * MAX_COLS + rc + dc];
				sum += (a > b) ? a - b : b - a;
			end
		end
		return sum;
	endfunction

	function automatic ssd_pkg::result_t predict_disparity(input int r, input int c);
		ssd_pkg::result_t res;
		int               w;
		int               h;
		int               best_sum;
		int               best_col;
		int               s;
		int               d;
		res = '0;
		w = cur_width();
		h = cur_height();
		if (r >= h || c >= w) begin
			res.out_of_range = 1'b1;
			return res;
		end
		if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
			return res;
		// Strictly smaller sums replace the best, so the lowest column wins a tie.
		best_sum = window_sad(r, c, 1);
		best_col = 1;
		for (int k = 2; k + 1 < w; k++) begin
			s = window_sad(r, c, k);
			if (s < best_sum) begin
				best_sum = s;
				best_col = k;
			end
		end
		d = (c > best_col) ? c - best_col : best_col - c;
		if (d > 255)
			d = 255;
		res.disparity = d[7:0];
		return res;
	endfunction

	// A query on a band is legal only once all three rows are loaded across the
	// configured width, since the right image is scanned over every column.
	function automatic bit band_loaded(input int r, input int w);
		for (int rr = r - 1; rr <= r + 1; rr++)
			for (int cc = 0; cc < w; cc++)
				if (!pixel_loaded[rr * MAX_COLS + cc])
					return 1'b0;
		return 1'b1;
	endfunction

	// Out-of-range and border queries read nothing from the stores.
	function automatic bit query_reads_loaded(input int r, input int c);
		int w;
		int h;
		w = cur_width();
		h = cur_height();
		if (r >= h || c >= w)
			return 1'b1;
		if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
			return 1'b1;
		return band_loaded(r, w);
	endfunction

	// Applies one accepted transfer to the mirror, or records the result it owes.
	function automatic void track_item(input ssd_pkg::item_t it);
		int addr;
		if (it.opcode == ssd_pkg::OP_LOAD) begin
			if (it.row < MAX_ROWS && it.col < MAX_COLS) begin
				addr = it.row * MAX_COLS + it.col;
				left_img[addr] = it.left_pixel;
				right_img[addr] = it.right_pixel;
				pixel_loaded[addr] = 1'b1;
			end
		end else begin
			pending_results.insert(pending_results.size(),
				predict_disparity(it.row, it.col));
		end
	endfunction

	function automatic ssd_pkg::item_t make_load(input int r, input int c,
			input logic [ssd_pkg::PIX_W-1:0] lp, input logic [ssd_pkg::PIX_W-1:0] rp);
		ssd_pkg::item_t it;
		it.opcode = ssd_pkg::OP_LOAD;
		it.row = 7'(r);
		it.col = 7'(c);
		it.left_pixel = lp;
		it.right_pixel = rp;
		return it;
	endfunction

	// The pixel fields of a query are ignored, so they carry random bits.
	function automatic ssd_pkg::item_t make_query(input int r, input int c);
		ssd_pkg::item_t it;
		it.opcode = ssd_pkg::OP_QUERY;
		it.row = 7'(r);
		it.col = 7'(c);
		it.left_pixel = ssd_pkg::PIX_W'($urandom);
		it.right_pixel = ssd_pkg::PIX_W'($urandom);
		return it;
	endfunction

	function automatic logic [ssd_pkg::PIX_W-1:0] pick_pixel(input fill_mode_t mode,
			input logic [ssd_pkg::PIX_W-1:0] flat_value);
		case (mode)
			FILL_FLAT:    return flat_value;
			FILL_NARROW:  return ssd_pkg::PIX_W'($urandom_range(3));
			FILL_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
			default:      return ssd_pkg::PIX_W'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus and result checking.
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Sends one transfer. Start is left high on return so that a following
	// transfer can go out on the very next edge; a gap lowers it first.
	task automatic issue_item(input ssd_pkg::item_t it);
		if (gaps_on) begin
			while ($urandom_range(99) < GAP_PCT) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		track_item(it);
		items_sent++;
	endtask

	// Issues a query only when it cannot read an unloaded pixel.
	task automatic issue_query(input int r, input int c);
		if (query_reads_loaded(r, c))
			issue_item(make_query(r, c));
	endtask

	// Brings the block to rest: no owed result, a short pause for a trailing
	// load, and busy low.
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LOAD_SETTLE_CYCLES)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Writes both size registers on consecutive edges while the block is idle.
	task automatic set_size(input logic [ssd_pkg::DIM_W-1:0] w,
			input logic [ssd_pkg::DIM_W-1:0] h);
		settle();
		cfg_we <= 1'b1;
		cfg_idx <= ssd_pkg::CFG_IMAGE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		width_reg = w;
		cfg_idx <= ssd_pkg::CFG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		height_reg = h;
		cfg_we <= 1'b0;
	endtask

	// Loads rows center-1 .. center+1 over columns 0 .. w-1. The right row is
	// the left row rotated by a random shift, with a little noise in the
	// shifted mode, so that the best match sits at a known offset.
	task automatic load_band(input int center, input int w, input fill_mode_t mode);
		logic [ssd_pkg::PIX_W-1:0] row_pix [MAX_COLS];
		logic [ssd_pkg::PIX_W-1:0] flat_value;
		logic [ssd_pkg::PIX_W-1:0] rp;
		int                        shift;
		flat_value = ssd_pkg::PIX_W'($urandom);
		shift = $urandom_range(w - 1);
		for (int r = center - 1; r <= center + 1; r++) begin
			for (int c = 0; c < w; c++)
				row_pix[c] = pick_pixel(mode, flat_value);
			for (int c = 0; c < w; c++) begin
				rp = row_pix[(c + shift) % w];
				if (mode == FILL_SHIFTED && $urandom_range(3) == 0)
					rp = rp ^ ssd_pkg::PIX_W'($urandom_range(3));
				issue_item(make_load(r, c, row_pix[c], rp));
			end
		end
	endtask

	// Each result is taken at the edge that ends its one-cycle strobe and is
	// compared with the oldest owed result.
	always @(posedge clk) begin : check_results
		ssd_pkg::result_t want;
		if (arst_n) begin
			if ($isunknown(done)) begin
				flag_mismatch("result strobe is unknown");
			end else if (done) begin
				if (pending_results.size() == 0) begin
					flag_mismatch($sformatf("result with none owed: disparity %0d oor %0b",
						result.disparity, result.out_of_range));
				end else begin
					want = pending_results.pop_front();
					if (result.disparity !== want.disparity)
						flag_mismatch($sformatf("disparity %0d, expected %0d",
							result.disparity, want.disparity));
					if (result.out_of_range !== want.out_of_range)
						flag_mismatch($sformatf("out_of_range %0b, expected %0b",
							result.out_of_range, want.out_of_range));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// At the reset size of 128 by 128 only border queries are legal before
	// anything is loaded; they cover the corners and every edge.
	task automatic test_border_after_reset();
		issue_query(0, 0);
		issue_query(0, 127);
		issue_query(127, 0);
		issue_query(127, 127);
		issue_query(0, 85);
		issue_query(42, 0);
		issue_query(85, 127);
		issue_query(127, 42);
	endtask

	// The smallest image has a single interior pixel and a single candidate
	// column. Pixels alternate between the darkest and brightest values.
	task automatic test_min_image();
		set_size(8'd3, 8'd3);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				issue_item(make_load(r, c, ((r + c) % 2) ? 8'hFF : 8'h00,
					((r + c) % 2) ? 8'h00 : 8'hFF));
		issue_query(1, 1);
		issue_query(0, 1);
		issue_query(2, 1);
		issue_query(1, 0);
		issue_query(1, 2);
		issue_query(3, 1);
		issue_query(1, 3);
		issue_query(127, 127);
	endtask

	// A flat band makes every candidate tie, so the lowest column must win;
	// a shifted band gives a clear best match.
	task automatic test_ties_and_match();
		set_size(8'd8, 8'd3);
		load_band(1, 8, FILL_FLAT);
		issue_query(1, 6);
		issue_query(1, 1);
		load_band(1, 8, FILL_SHIFTED);
		for (int c = 1; c <= 6; c++)
			issue_query(1, c);
	endtask

	// Register values below 3 and above the store size are clamped.
	task automatic test_size_clamp();
		set_size(8'd0, 8'd255);
		issue_query(1, 1);
		issue_query(1, 3);
		issue_query(1, 2);
		issue_query(127, 1);
		set_size(8'd255, 8'd1);
		issue_query(1, 127);
		issue_query(3, 5);
		issue_query(2, 50);
		issue_query(1, 0);
		set_size(8'd2, 8'd129);
		issue_query(1, 1);
		issue_query(126, 2);
		issue_query(100, 3);
	endtask

	// The largest image, on the last interior row, scans all 126 candidates.
	task automatic test_full_size();
		set_size(8'd128, 8'd128);
		load_band(126, 128, FILL_SHIFTED);
		issue_query(126, 1);
		issue_query(126, 126);
		issue_query(126, 127);
		repeat (6)
			issue_query(126, $urandom_range(1, 126));
	endtask

	// Random phases: pick a size, load a few bands, query them, and mix in
	// loads and queries anywhere in the stores. Most widths are small so that
	// queries stay short; one phase runs with no gaps at all.
	task automatic test_random_traffic();
		int                        target;
		int                        phase;
		int                        w;
		int                        h;
		int                        center;
		int                        bands;
		logic [ssd_pkg::DIM_W-1:0] raw_w;
		logic [ssd_pkg::DIM_W-1:0] raw_h;
		fill_mode_t                mode;
		target = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < target) begin
			case ($urandom_range(9))
				0:       raw_w = ssd_pkg::DIM_W'($urandom_range(1) ? $urandom_range(0, 2) :
					$urandom_range(129, 255));
				1:       raw_w = ssd_pkg::DIM_W'($urandom_range(32, 128));
				default: raw_w = ssd_pkg::DIM_W'($urandom_range(3, 12));
			endcase
			case ($urandom_range(9))
				0:       raw_h = ssd_pkg::DIM_W'($urandom_range(1) ? $urandom_range(0, 2) :
					$urandom_range(129, 255));
				1, 2:    raw_h = ssd_pkg::DIM_W'($urandom_range(3, 128));
				default: raw_h = ssd_pkg::DIM_W'($urandom_range(3, 16));
			endcase
			set_size(raw_w, raw_h);
			w = cur_width();
			h = cur_height();
			gaps_on = (phase != 2);
			bands = gaps_on ? $urandom_range(1, 3) : 4;
			repeat (bands) begin
				center = $urandom_range(1, h - 2);
				mode = fill_mode_t'($urandom_range(3) == 0 ? $urandom_range(3) : FILL_SHIFTED);
				load_band(center, w, mode);
				repeat ($urandom_range(4, 12)) begin
					if ($urandom_range(4) == 0)
						issue_query(center + $urandom_range(2) - 1,
							$urandom_range(0, (w < MAX_COLS) ? w : MAX_COLS - 1));
					else
						issue_query(center, $urandom_range(1, w - 2));
				end
				// Stray traffic anywhere, including beyond the configured size.
				repeat ($urandom_range(0, 3))
					issue_item(make_load($urandom_range(127), $urandom_range(127),
						ssd_pkg::PIX_W'($urandom), ssd_pkg::PIX_W'($urandom)));
				repeat ($urandom_range(0, 2))
					issue_query($urandom_range(127), $urandom_range(127));
			end
			phase++;
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_border_after_reset();
		test_min_image();
		test_ties_and_match();
		test_size_clamp();
		test_full_size();
		test_random_traffic();

		// Collect every owed result, then watch a while longer for strays.
		settle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("timeout with %0d results still owed", pending_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
